### sv/dtfv_pkg.sv
// shared types, codes and character-class helpers for the field validator
// no dependencies
package dtfv_pkg;

   // field kinds
   localparam logic [3:0] KIND_ANY    = 4'd0;
   localparam logic [3:0] KIND_ADDR   = 4'd1;
   localparam logic [3:0] KIND_DOMAIN = 4'd2;
   localparam logic [3:0] KIND_HOST   = 4'd3;
   localparam logic [3:0] KIND_TOK2   = 4'd4;
   localparam logic [3:0] KIND_TOK_LO = 4'd5;
   localparam logic [3:0] KIND_TOK_HI = 4'd8;
   localparam logic [3:0] KIND_RTYPE  = 4'd9;

   // verdict codes
   localparam logic [1:0] VERDICT_INVALID = 2'd0;
   localparam logic [1:0] VERDICT_VALID   = 2'd1;
   localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;

   // characters of interest
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_LOW_S  = 8'h73;
   localparam logic [7:0] CH_UP_S   = 8'h53;
   localparam logic [7:0] CH_LOW_M  = 8'h6d;
   localparam logic [7:0] CH_UP_M   = 8'h4d;

   // octet limits and classful net codes
   localparam logic [8:0]  OCTET_MAX     = 9'd255;
   localparam logic [8:0]  GROUP_SAT     = 9'd256;
   localparam logic [2:0]  GROUPS_FULL   = 3'd4;
   localparam logic [2:0]  GROUPS_LAST   = 3'd3;
   localparam logic [15:0] CLASS_B_ZERO  = 16'h8000;
   localparam logic [23:0] CLASS_C_ZERO  = 24'hc00000;

   // address scan progress
   typedef enum logic [2:0] {
      FMT_SCAN = 3'b001,
      FMT_TAIL = 3'b010,
      FMT_FAIL = 3'b100
   } dtfv_fmt_type;

   // one classified word as it travels from front to back
   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] ch;
      logic       has_char;
      logic       last;
      logic       is_digit;
      logic       is_dot;
      logic       is_space;
      logic       is_name;
      logic [3:0] digit;
   } dtfv_item_type;

   function automatic logic is_digit_f(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alnum_f(input logic [7:0] c);
      return is_digit_f(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
             ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

endpackage

### sv/dtfv_front.sv
// front end: takes request words and tags each character with its classes
// depends on dtfv_pkg
module dtfv_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [3:0]             req_type,
   input  logic [7:0]             req_ch,
   input  logic                   req_has_char,
   input  logic                   req_last,
   input  logic                   q_full,
   output logic                   q_push,
   output dtfv_pkg::dtfv_item_type q_item
);
   import dtfv_pkg::*;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item          = '0;
      q_item.kind     = req_type;
      q_item.ch       = req_ch;
      q_item.has_char = req_has_char;
      q_item.last     = req_last;
      q_item.is_digit = is_digit_f(req_ch);
      q_item.is_dot   = (req_ch == CH_DOT);
      // space, tab, lf, vt, ff, cr
      q_item.is_space = (req_ch == 8'h20) || ((req_ch >= 8'h09) && (req_ch <= 8'h0d));
      q_item.is_name  = is_alnum_f(req_ch) || (req_ch == CH_DOT) ||
                        (req_ch == CH_UNDER) || (req_ch == CH_DASH);
      q_item.digit    = req_ch[3:0];
   end

endmodule

### sv/dtfv_queue.sv
// two-entry queue of classified words between front and back
// depends on dtfv_pkg
module dtfv_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dtfv_pkg::dtfv_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output dtfv_pkg::dtfv_item_type head_item
);
   import dtfv_pkg::*;

   dtfv_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/dtfv_back.sv
// back end: per-string counters and flags, verdict and the response register
// depends on dtfv_pkg
module dtfv_back #(
   parameter int DOMAIN_MAX_LEN = 1025,
   parameter int HOST_MAX_LEN   = 256,
   parameter int LABEL_MAX      = 63,
   parameter int KIND_MAX       = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_not_empty,
   input  dtfv_pkg::dtfv_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_verdict
);
   import dtfv_pkg::*;

   localparam logic [10:0] DOMAIN_LIM = 11'(DOMAIN_MAX_LEN);
   localparam logic [10:0] HOST_LIM   = 11'(HOST_MAX_LEN);
   localparam logic [6:0]  LABEL_LIM  = 7'(LABEL_MAX);
   localparam logic [3:0]  KIND_LIM   = 4'(KIND_MAX);
   localparam logic [10:0] COUNT_SAT  = 11'h7ff;

   logic          in_string_ff, in_string_in;
   logic [3:0]    kind_ff, kind_in;
   logic [10:0]   count_ff, count_in;
   logic [6:0]    label_len_ff, label_len_in;
   logic          label_long_ff, label_long_in;
   logic          bad_ff, bad_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    prev_ff, prev_in;
   logic [2:0]    gidx_ff, gidx_in;
   logic [8:0]    gval_ff, gval_in;
   logic          ghas_ff, ghas_in;
   logic [31:0]   addr_ff, addr_in;
   dtfv_fmt_type  fmt_ff, fmt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    verdict_ff, verdict_in;

   logic [11:0]   gprod;
   logic          slot_free;
   logic [31:0]   fin_addr;
   logic          fin_ok;
   logic          addr_ok;
   logic [1:0]    verdict_now;

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign q_pop       = q_not_empty && slot_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   // state update for the word at the head of the queue
   always_comb begin
      in_string_in  = in_string_ff;
      kind_in       = kind_ff;
      count_in      = count_ff;
      label_len_in  = label_len_ff;
      label_long_in = label_long_ff;
      bad_in        = bad_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      gidx_in       = gidx_ff;
      gval_in       = gval_ff;
      ghas_in       = ghas_ff;
      addr_in       = addr_ff;
      fmt_in        = fmt_ff;
      gprod         = ({3'b0, gval_ff} << 3) + ({3'b0, gval_ff} << 1) + {8'b0, q_item.digit};
      if (q_pop) begin
         if (!in_string_ff) begin
            in_string_in  = 1'b1;
            kind_in       = q_item.kind;
            count_in      = '0;
            label_len_in  = '0;
            label_long_in = 1'b0;
            bad_in        = 1'b0;
            first_in      = '0;
            prev_in       = '0;
            gidx_in       = '0;
            gval_in       = '0;
            ghas_in       = 1'b0;
            addr_in       = '0;
            fmt_in        = FMT_SCAN;
            gprod         = {8'b0, q_item.digit};
         end
         if (q_item.has_char) begin
            if (count_in == '0) begin
               first_in = q_item.ch;
            end
            if (kind_in == KIND_ADDR) begin
               if (!q_item.is_digit && !q_item.is_dot) begin
                  bad_in = 1'b1;
               end else if (fmt_in == FMT_SCAN) begin
                  if (q_item.is_digit) begin
                     if (gidx_in >= GROUPS_FULL) begin
                        fmt_in = FMT_FAIL;
                     end else begin
                        gval_in = (gprod > 12'(GROUP_SAT)) ? GROUP_SAT : gprod[8:0];
                        ghas_in = 1'b1;
                     end
                  end else if (!ghas_in) begin
                     // a dot with no digits before it: ".." tail only after four octets
                     fmt_in = (gidx_in == GROUPS_FULL) ? FMT_TAIL : FMT_FAIL;
                  end else if (gval_in > OCTET_MAX) begin
                     fmt_in = FMT_FAIL;
                  end else begin
                     addr_in = {addr_in[23:0], gval_in[7:0]};
                     gidx_in = gidx_in + 3'd1;
                     gval_in = '0;
                     ghas_in = 1'b0;
                  end
               end
            end else if ((kind_in == KIND_DOMAIN) || (kind_in == KIND_HOST)) begin
               if (!q_item.is_name) begin
                  bad_in = 1'b1;
               end
               if (q_item.is_dot) begin
                  label_len_in = '0;
               end else if (label_len_in >= LABEL_LIM) begin
                  label_long_in = 1'b1;
               end else begin
                  label_len_in = label_len_in + 7'd1;
               end
            end else if ((kind_in inside {[KIND_TOK2:KIND_TOK_HI]}) && q_item.is_space) begin
               bad_in = 1'b1;
            end
            prev_in = q_item.ch;
            if (count_in != COUNT_SAT) begin
               count_in = count_in + 11'd1;
            end
         end
         if (q_item.last) begin
            in_string_in = 1'b0;
         end
      end
   end

   // closing the fourth octet at end of string
   always_comb begin
      fin_addr = addr_in;
      fin_ok   = (fmt_in == FMT_TAIL) || ((fmt_in == FMT_SCAN) && (gidx_in == GROUPS_FULL));
      if ((fmt_in == FMT_SCAN) && (gidx_in == GROUPS_LAST) && ghas_in &&
          (gval_in <= OCTET_MAX)) begin
         fin_addr = {addr_in[23:0], gval_in[7:0]};
         fin_ok   = 1'b1;
      end
   end

   // classful net and host rules
   always_comb begin
      addr_ok = 1'b0;
      if (!fin_addr[31]) begin
         addr_ok = (fin_addr[31:24] != '0) && (fin_addr[23:0] != '0) &&
                   (fin_addr[23:0] != '1);
      end else if (fin_addr[31:30] == 2'b10) begin
         addr_ok = (fin_addr[31:16] != CLASS_B_ZERO) && (fin_addr[15:0] != '0) &&
                   (fin_addr[15:0] != '1);
      end else if (fin_addr[31:29] == 3'b110) begin
         addr_ok = (fin_addr[31:8] != CLASS_C_ZERO) && (fin_addr[7:0] != '0) &&
                   (fin_addr[7:0] != '1);
      end
      if ((count_in == '0) || bad_in || (prev_in == CH_DOT) || !fin_ok) begin
         addr_ok = 1'b0;
      end
   end

   always_comb begin
      verdict_now = VERDICT_INVALID;
      if (kind_in > KIND_LIM) begin
         verdict_now = VERDICT_UNKNOWN;
      end else begin
         case (kind_in)
            KIND_ANY: verdict_now = VERDICT_VALID;
            KIND_ADDR: verdict_now = addr_ok ? VERDICT_VALID : VERDICT_INVALID;
            KIND_DOMAIN: begin
               if ((count_in != '0) && (count_in < DOMAIN_LIM) && !bad_in &&
                   !label_long_in && (first_in != CH_DASH) && (prev_in != CH_DASH)) begin
                  verdict_now = VERDICT_VALID;
               end
            end
            KIND_HOST: begin
               if ((count_in > 11'd1) && (count_in < HOST_LIM) && !bad_in &&
                   !label_long_in && is_alnum_f(first_in) && is_alnum_f(prev_in)) begin
                  verdict_now = VERDICT_VALID;
               end
            end
            KIND_TOK2: begin
               if (!bad_in && (count_in > 11'd1)) begin
                  verdict_now = VERDICT_VALID;
               end
            end
            KIND_RTYPE: begin
               if ((count_in == 11'd1) &&
                   ((first_in == CH_LOW_S) || (first_in == CH_UP_S) ||
                    (first_in == CH_LOW_M) || (first_in == CH_UP_M))) begin
                  verdict_now = VERDICT_VALID;
               end
            end
            default: begin
               if ((kind_in inside {[KIND_TOK_LO:KIND_TOK_HI]}) && !bad_in &&
                   (count_in != '0)) begin
                  verdict_now = VERDICT_VALID;
               end
            end
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      if (q_pop && q_item.last) begin
         rsp_valid_in = 1'b1;
         verdict_in   = verdict_now;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff  <= 1'b0;
         kind_ff       <= '0;
         count_ff      <= '0;
         label_len_ff  <= '0;
         label_long_ff <= 1'b0;
         bad_ff        <= 1'b0;
         first_ff      <= '0;
         prev_ff       <= '0;
         gidx_ff       <= '0;
         gval_ff       <= '0;
         ghas_ff       <= 1'b0;
         addr_ff       <= '0;
         fmt_ff        <= FMT_SCAN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_string_ff  <= in_string_in;
         kind_ff       <= kind_in;
         count_ff      <= count_in;
         label_len_ff  <= label_len_in;
         label_long_ff <= label_long_in;
         bad_ff        <= bad_in;
         first_ff      <= first_in;
         prev_ff       <= prev_in;
         gidx_ff       <= gidx_in;
         gval_ff       <= gval_in;
         ghas_ff       <= ghas_in;
         addr_ff       <= addr_in;
         fmt_ff        <= fmt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

endmodule

### sv/dhcp_table_field_validator_unit.sv
// top level of the text field validator: front end, word queue and back end
// depends on dtfv_pkg, dtfv_front, dtfv_queue, dtfv_back
//
// usage
//   a string is sent as a run of request words, one character per word, the
//   final word marked by req_last; req_type on the first word picks the field
//   kind, and a word with req_has_char low carries no character (an empty
//   string is one such word with req_last high)
//   each string gives exactly one response word, rsp_verdict: invalid, valid
//   or unknown kind; words without req_last give nothing
// throughput
//   one word per cycle sustained while the response slot is free; the front end
//   tags the character classes and writes a two-entry queue, the back end pops
//   one word per cycle and updates the per-string counters in a single step
// response
//   rsp_valid rises once the last word has been written into the queue, popped
//   by the back end and its verdict registered in the response register
// stall
//   rsp_stall holds the response register; the back end keeps working while
//   the slot is taken in the same cycle, and only when the slot stays full
//   does the queue fill, after which req_stall rises
// reset: synchronous; empties the queue, drops any response, starts a new string
module dhcp_table_field_validator_unit #(
   parameter int DOMAIN_MAX_LEN = 1025,
   parameter int HOST_MAX_LEN   = 256,
   parameter int LABEL_MAX      = 63,
   parameter int KIND_MAX       = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_type,
   input  logic [7:0] req_ch,
   input  logic       req_has_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_verdict
);
   import dtfv_pkg::*;

   // classified word on its way into the queue
   dtfv_item_type push_item;
   dtfv_item_type head_item;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_not_empty;

   dtfv_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_ch       (req_ch),
      .req_has_char (req_has_char),
      .req_last     (req_last),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_item       (push_item)
   );

   // decouples acceptance from the response stall
   dtfv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // string state and the verdict register
   dtfv_back #(
      .DOMAIN_MAX_LEN (DOMAIN_MAX_LEN),
      .HOST_MAX_LEN   (HOST_MAX_LEN),
      .LABEL_MAX      (LABEL_MAX),
      .KIND_MAX       (KIND_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict)
   );

endmodule

### sv/dtfv_checker.sv
// port-level checks for the field validator, bound to the top level
// depends on dhcp_table_field_validator_unit
module dtfv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_verdict
);

   // strings ended on the request side and not yet answered
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_valid && !req_stall && req_last} -
                   {1'b0, rsp_valid && !rsp_stall};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_verdict_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_verdict))
      else $error("verdict changed while stalled");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a finished string");

endmodule

bind dhcp_table_field_validator_unit dtfv_checker u_checker (.*);

### bench/testbench.sv
// self-checking bench for dhcp_table_field_validator_unit: strings of field text,
// one character per word, each verdict compared with a cycle-free predictor
// depends on dtfv_pkg and the unit under test
`timescale 1ns / 1ps

module testbench;
   import dtfv_pkg::*;

   localparam int DOMAIN_MAX_LEN = 1025;
   localparam int HOST_MAX_LEN   = 256;
   localparam int LABEL_MAX      = 63;
   localparam int KIND_MAX       = 9;

   // kinds beyond the recognised range
   localparam logic [3:0] KIND_UNDEF_LO = 4'(KIND_MAX + 1);
   localparam logic [3:0] KIND_UNDEF_HI = 4'hf;

   localparam int PREDICTED   = -1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;

   // markers in the directed text: a word without character, a nul byte
   localparam logic [7:0] MARK_GAP = "#";
   localparam logic [7:0] MARK_NUL = "~";

   localparam string ALNUM    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   localparam string ADDR_SET = "0123456789..";
   localparam string NAME_BAD = "-._ -";
   localparam string RTYPE_SET = "sSmMxq";
   localparam int OCT_EDGE [15] = '{0, 1, 9, 10, 99, 100, 126, 127, 128, 191, 192, 223, 224,
                                    254, 255};

   typedef struct packed {
      logic [7:0] c;
      logic       has;
   } word_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [3:0] req_type;
   logic [7:0] req_ch;
   logic       req_has_char;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_verdict;

   dhcp_table_field_validator_unit #(
      .DOMAIN_MAX_LEN(DOMAIN_MAX_LEN),
      .HOST_MAX_LEN  (HOST_MAX_LEN),
      .LABEL_MAX     (LABEL_MAX),
      .KIND_MAX      (KIND_MAX)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_ch      (req_ch),
      .req_has_char(req_has_char),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor state: one string in flight
   // ---------------------------------------------------------------
   logic [3:0]   cur_kind;
   logic         open_str;
   logic [10:0]  n_chars;
   logic [6:0]   lbl_len;
   logic         lbl_long;
   logic         bad_seen;
   logic [7:0]   first_c;
   logic [7:0]   prev_c;
   logic [2:0]   grp_idx;
   logic [8:0]   grp_val;
   logic         grp_digit;
   logic [31:0]  addr_acc;
   dtfv_fmt_type scan_st;

   logic [1:0] verdict_q [$];
   int         forced_verdict = PREDICTED;
   int         err_count = 0;
   int         cycles = 0;
   int         words_sent = 0;
   int         snd_idle_pct = 0;
   int         rcv_stall_pct = 0;
   bit         hold_request = 1'b0;
   int         hold_left = 0;

   word_type   str_buf [$];
   logic [3:0] str_kind;

   function automatic logic is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alnum_c(logic [7:0] c);
      return is_dec(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_ws(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_label_c(logic [7:0] c);
      return is_alnum_c(c) || c == CH_DOT || c == CH_UNDER || c == CH_DASH;
   endfunction

   function automatic void fresh_string();
      n_chars = '0; lbl_len = '0; lbl_long = 1'b0; bad_seen = 1'b0;
      first_c = '0; prev_c = '0; grp_idx = '0; grp_val = '0;
      grp_digit = 1'b0; addr_acc = '0; scan_st = FMT_SCAN;
   endfunction

   // finished octet: shift it into the address or fail on overflow
   function automatic void close_group();
      if (grp_val > OCTET_MAX) begin
         scan_st = FMT_FAIL;
      end else begin
         addr_acc  = {addr_acc[23:0], grp_val[7:0]};
         grp_idx   = grp_idx + 3'd1;
         grp_val   = '0;
         grp_digit = 1'b0;
      end
   endfunction

   function automatic void feed_address(logic [7:0] c);
      int val;
      if (!is_dec(c) && c != CH_DOT) begin
         bad_seen = 1'b1;
      end else if (scan_st == FMT_SCAN) begin
         if (is_dec(c)) begin
            if (grp_idx >= GROUPS_FULL) begin
               scan_st = FMT_FAIL;
            end else begin
               val = int'(grp_val) * 10 + int'(c) - int'(8'h30);
               grp_val   = (val > 256) ? GROUP_SAT : 9'(val);
               grp_digit = 1'b1;
            end
         end else if (!grp_digit) begin
            // a second dot after four octets opens the tolerated tail
            if (grp_idx == GROUPS_FULL) scan_st = FMT_TAIL;
            else scan_st = FMT_FAIL;
         end else begin
            close_group();
         end
      end
   endfunction

   function automatic void feed_label(logic [7:0] c);
      if (!is_label_c(c)) bad_seen = 1'b1;
      if (c == CH_DOT) lbl_len = '0;
      else if (lbl_len >= LABEL_MAX) lbl_long = 1'b1;
      else lbl_len = lbl_len + 7'd1;
   endfunction

   function automatic logic address_legal();
      logic [31:0] a;
      if (n_chars == 0 || bad_seen || prev_c == CH_DOT) return 1'b0;
      if (scan_st == FMT_SCAN && grp_idx == GROUPS_LAST && grp_digit) close_group();
      if (!(scan_st == FMT_TAIL || (scan_st == FMT_SCAN && grp_idx == GROUPS_FULL)))
         return 1'b0;
      a = addr_acc;
      if (!a[31])
         return a[31:24] != 8'h0 && a[23:0] != 24'h0 && a[23:0] != 24'hffffff;
      if (a[31:30] == 2'b10)
         return a[31:16] != CLASS_B_ZERO && a[15:0] != 16'h0 && a[15:0] != 16'hffff;
      if (a[31:29] == 3'b110)
         return a[31:8] != CLASS_C_ZERO && a[7:0] != 8'h0 && a[7:0] != 8'hff;
      return 1'b0;
   endfunction

   function automatic logic [1:0] judge_string();
      logic ok;
      if (cur_kind > KIND_MAX) return VERDICT_UNKNOWN;
      case (cur_kind)
         KIND_ANY:    ok = 1'b1;
         KIND_ADDR:   ok = address_legal();
         KIND_DOMAIN: ok = n_chars > 0 && n_chars < DOMAIN_MAX_LEN && !bad_seen && !lbl_long &&
                           first_c != CH_DASH && prev_c != CH_DASH;
         KIND_HOST:   ok = n_chars > 1 && n_chars < HOST_MAX_LEN && !bad_seen && !lbl_long &&
                           is_alnum_c(first_c) && is_alnum_c(prev_c);
         KIND_TOK2:   ok = !bad_seen && n_chars > 1;
         KIND_RTYPE:  ok = n_chars == 1 && (first_c == CH_LOW_S || first_c == CH_UP_S ||
                           first_c == CH_LOW_M || first_c == CH_UP_M);
         default:     ok = cur_kind >= KIND_TOK_LO && cur_kind <= KIND_TOK_HI &&
                           !bad_seen && n_chars > 0;
      endcase
      return ok ? VERDICT_VALID : VERDICT_INVALID;
   endfunction

   // one accepted word; returns 1 when the string closes with a verdict
   function automatic bit field_verdict_step(logic [3:0] kind, logic [7:0] c, logic has,
                                             logic lst, output logic [1:0] v);
      if (!open_str) begin
         fresh_string();
         cur_kind = kind;
         open_str = 1'b1;
      end
      if (has) begin
         if (n_chars == 0) first_c = c;
         if (cur_kind == KIND_ADDR) feed_address(c);
         else if (cur_kind == KIND_DOMAIN || cur_kind == KIND_HOST) feed_label(c);
         else if (cur_kind >= KIND_TOK2 && cur_kind <= KIND_TOK_HI && is_ws(c))
            bad_seen = 1'b1;
         prev_c = c;
         if (n_chars != 11'h7ff) n_chars = n_chars + 11'd1;
      end
      v = VERDICT_INVALID;
      if (lst) begin
         v = judge_string();
         open_str = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // checker and predictor feed, both at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch
      logic [1:0] v;
      logic [1:0] want;
      bit         got;
      if (!reset) begin
         cycles = cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            if (rsp_valid && !rsp_stall) begin
               if (verdict_q.size() == 0) begin
                  $error("rsp_verdict: no verdict pending, actual %0d", rsp_verdict);
                  err_count = err_count + 1;
               end else begin
                  want = verdict_q.pop_front();
                  if (rsp_verdict !== want) begin
                     $error("rsp_verdict: expected %0d, actual %0d", want, rsp_verdict);
                     err_count = err_count + 1;
                  end
               end
            end
            if (req_valid && !req_stall) begin
               got = field_verdict_step(req_type, req_ch, req_has_char, req_last, v);
               if (got) verdict_q.push_back(forced_verdict >= 0 ? 2'(forced_verdict) : v);
            end
         end
      end
   end

   // receiver: random stall, or a long hold-off counted here
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   task automatic send_word(logic [3:0] kind, word_type w, logic lst, int ovr);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid    <= 1'b0;
         req_type     <= 4'($urandom);
         req_ch       <= 8'($urandom);
         req_has_char <= 1'($urandom);
         req_last     <= 1'($urandom);
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_ch         <= w.c;
      req_has_char   <= w.has;
      req_last       <= lst;
      forced_verdict = lst ? ovr : PREDICTED;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent = words_sent + 1;
      @(negedge clock);
   endtask

   // kind only counts on the first word, so later words carry noise there
   task automatic send_string(logic [3:0] kind, int ovr);
      int       n;
      word_type w;
      n = str_buf.size();
      if (n == 0) begin
         w.c = 8'($urandom);
         w.has = 1'b0;
         send_word(kind, w, 1'b1, ovr);
      end else begin
         for (int i = 0; i < n; i++)
            send_word(i == 0 ? kind : 4'($urandom), str_buf[i], i == n - 1, ovr);
      end
   endtask

   task automatic push_char(logic [7:0] c);
      word_type w;
      w.c = c;
      w.has = 1'b1;
      str_buf.push_back(w);
   endtask

   function automatic logic [7:0] pick_from(string pool);
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   // overwrite one character, from a pool or any byte
   task automatic spoil(string pool);
      int       pos;
      word_type w;
      if (str_buf.size() != 0) begin
         pos = $urandom_range(str_buf.size() - 1);
         w = str_buf[pos];
         w.c = ($urandom_range(3) == 0) ? 8'($urandom) : pick_from(pool);
         w.has = 1'b1;
         str_buf[pos] = w;
      end
   endtask

   task automatic make_address();
      int    groups, v, r;
      string s;
      groups = ($urandom_range(9) == 0) ? $urandom_range(2, 5) : 4;
      for (int g = 0; g < groups; g++) begin
         if (g > 0) push_char(CH_DOT);
         r = $urandom_range(9);
         if (r < 5) v = OCT_EDGE[$urandom_range(14)];
         else if (r < 8) v = $urandom_range(255);
         else if (r == 8) v = $urandom_range(256, 999);
         else v = $urandom_range(1000, 99999);
         if ($urandom_range(19) == 0) push_char("0");
         s = $sformatf("%0d", v);
         for (int j = 0; j < s.len(); j++) push_char(s[j]);
      end
      // tolerated double dot tail, then a stray trailing dot
      if ($urandom_range(6) == 0) begin
         push_char(CH_DOT);
         push_char(CH_DOT);
         repeat ($urandom_range(3)) push_char(pick_from(ADDR_SET));
      end
      if ($urandom_range(9) == 0) push_char(CH_DOT);
      if ($urandom_range(7) == 0) spoil(ADDR_SET);
   endtask

   task automatic make_name();
      int len, r;
      repeat ($urandom_range(1, 4)) begin
         if (str_buf.size() != 0) push_char(CH_DOT);
         len = ($urandom_range(29) == 0) ? $urandom_range(LABEL_MAX - 1, LABEL_MAX + 2)
                                         : $urandom_range(1, 8);
         repeat (len) begin
            r = $urandom_range(99);
            if (r < 85) push_char(pick_from(ALNUM));
            else if (r < 92) push_char(CH_DASH);
            else push_char(CH_UNDER);
         end
      end
      if ($urandom_range(6) == 0) spoil(NAME_BAD);
   endtask

   task automatic make_token();
      int r;
      repeat ($urandom_range(6)) begin
         r = $urandom_range(99);
         if (r < 80) push_char(8'($urandom_range(33, 126)));
         else if (r < 90) push_char(($urandom_range(5) == 0) ? " " : 8'($urandom_range(9, 13)));
         else push_char(8'($urandom));
      end
   endtask

   // labels of thirty-nine so only the length limit matters
   task automatic make_long(int len);
      str_buf.delete();
      for (int i = 0; i < len; i++)
         push_char((i % 40 == 39 && i != len - 1) ? CH_DOT : pick_from(ALNUM));
   endtask

   task automatic build_random();
      int       pick;
      word_type w;
      str_buf.delete();
      pick = $urandom_range(99);
      if (pick < 30) begin
         str_kind = KIND_ADDR;
         make_address();
      end else if (pick < 45) begin
         str_kind = KIND_DOMAIN;
         make_name();
      end else if (pick < 60) begin
         str_kind = KIND_HOST;
         make_name();
      end else if (pick < 80) begin
         str_kind = ($urandom_range(5) == 0) ? KIND_ANY
                                             : 4'($urandom_range(KIND_TOK2, KIND_TOK_HI));
         make_token();
      end else if (pick < 90) begin
         str_kind = KIND_RTYPE;
         repeat ($urandom_range(2)) push_char(pick_from(RTYPE_SET));
      end else begin
         str_kind = 4'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
         make_token();
      end
      if ($urandom_range(32) == 0) str_buf.delete();
      if ($urandom_range(9) == 0) begin
         w.c = 8'($urandom);
         w.has = 1'b0;
         str_buf.insert($urandom_range(str_buf.size()), w);
      end
   endtask

   task automatic run_random(int count);
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         build_random();
         send_string(str_kind, PREDICTED);
      end
   endtask

   // stop offering and let every pending verdict come back; ends on a rising edge
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic begin_phase(int snd, int rcv, bit hold);
      snd_idle_pct  = snd;
      rcv_stall_pct = rcv;
      if (hold) hold_request = 1'b1;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // directed strings: kind, text, verdict where obvious
   // ---------------------------------------------------------------
   localparam int DIR_ROWS = 26;

   logic [3:0] dir_kind [DIR_ROWS] = '{
      KIND_ANY, KIND_ADDR, KIND_UNDEF_HI, KIND_UNDEF_LO, KIND_TOK_LO,
      KIND_ADDR, KIND_ADDR, KIND_ADDR, KIND_ADDR, KIND_ADDR,
      KIND_ADDR, KIND_ADDR, KIND_ADDR, KIND_ADDR, KIND_ADDR,
      KIND_DOMAIN, KIND_DOMAIN, KIND_HOST, KIND_HOST, KIND_HOST,
      KIND_TOK2, KIND_TOK2, KIND_TOK_HI, KIND_TOK_LO, KIND_RTYPE, KIND_RTYPE};

   string dir_text [DIR_ROWS] = '{
      "", "", "abc", "x", "##",
      "10.1.2.3", "255.255.255.255", "1.2.3.4..9", "1.2.3.4.5", "300.1.1.1",
      "128.0.0.1", "192.168.1.255", "1.2.3", "0.1.2.3", "1.2.3.4.",
      "-a.b", "a_b.c-d", "h", "host-1.x", "a~b",
      "a b", "x", "#t", "\t", "S", "mm"};

   int dir_verdict [DIR_ROWS] = '{
      int'(VERDICT_VALID), int'(VERDICT_INVALID), int'(VERDICT_UNKNOWN),
      int'(VERDICT_UNKNOWN), int'(VERDICT_INVALID),
      PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED,
      PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED,
      PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED,
      PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED};

   initial begin : stimulus
      string      s;
      logic [7:0] c;
      word_type   w;
      open_str = 1'b0;
      cur_kind = KIND_ANY;
      fresh_string();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = '0;
      req_ch       = '0;
      req_has_char = 1'b0;
      req_last     = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full rate: directed rows, length limits, then random strings
      for (int r = 0; r < DIR_ROWS; r++) begin
         str_buf.delete();
         s = dir_text[r];
         for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == MARK_GAP) begin
               w.c = 8'($urandom);
               w.has = 1'b0;
               str_buf.push_back(w);
            end else begin
               push_char(c == MARK_NUL ? 8'h00 : c);
            end
         end
         send_string(dir_kind[r], dir_verdict[r]);
      end
      make_long(HOST_MAX_LEN - 1);
      send_string(KIND_HOST, PREDICTED);
      make_long(HOST_MAX_LEN);
      send_string(KIND_HOST, PREDICTED);
      make_long(DOMAIN_MAX_LEN - 1);
      send_string(KIND_DOMAIN, PREDICTED);
      // past the saturation point of the character count
      make_long(2060);
      send_string(KIND_DOMAIN, PREDICTED);
      run_random(250);
      wait_drained();

      begin_phase(83, 0, 1'b0);
      run_random(200);
      wait_drained();

      begin_phase(0, 83, 1'b0);
      run_random(200);
      wait_drained();

      begin_phase(31, 31, 1'b0);
      run_random(200);
      wait_drained();

      // long receiver hold-off at full input rate: queue fills, req_stall rises
      begin_phase(0, 0, 1'b1);
      run_random(200);
      wait_drained();

      repeat (16) @(posedge clock);
      if (err_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
sv/dtfv_pkg.sv
sv/dtfv_front.sv
sv/dtfv_queue.sv
sv/dtfv_back.sv
sv/dhcp_table_field_validator_unit.sv
sv/dtfv_checker.sv
bench/testbench.sv
